// ===== rtl/core/crsf_pkg.sv =====
// Shared types, constants and helper functions for the CRSF frame receiver.
// Used by crsf_parser, crsf_emitter and crsf_frame_receiver; no dependencies.
package crsf_pkg;

  localparam int          MAX_FRAME_DEF = 64;
  localparam int          NUM_CHANNELS  = 16;
  localparam int          CH_BITS       = 11;
  // Bytes that the channel and link decodes can ever read.
  localparam int          STORE_BYTES   = (NUM_CHANNELS * CH_BITS + 7) / 8;

  localparam logic [7:0]  ADDR_RESET    = 8'hC8;
  localparam logic [7:0]  TYPE_RC       = 8'h16;
  localparam logic [7:0]  TYPE_LINK     = 8'h14;
  localparam logic [7:0]  CRC_POLY      = 8'hD5;
  localparam logic [7:0]  LEN_MIN_EXCL  = 8'd2;
  localparam logic [11:0] CHAN_OFFSET   = 12'd880;
  localparam logic [7:0]  RF_MODE_MAX   = 8'd3;

  // Register indexes on the configuration port.
  localparam logic        REG_FRAME_ADDR = 1'b0;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_LEN  = 2'd1,
    PH_TYPE = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAN    = 2'd0,
    KIND_LINK    = 2'd1,
    KIND_CRC_ERR = 2'd2
  } kind_t;

  // Decoded frame handed from the parser to the result stage.
  typedef struct packed {
    logic                              valid;
    kind_t                             kind;
    logic [NUM_CHANNELS-1:0][11:0]     vals;
    logic signed [8:0]                 rssi_neg;
    logic [1:0]                        rf_mode;
    logic [7:0]                        uplink_lq;
  } frame_evt_t;

  // CRC-8 DVB-S2, MSB first, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // raw * 5 / 8 + 880
  function automatic logic [11:0] chan_scale(input logic [CH_BITS-1:0] raw);
    logic [13:0] p;
    p = {1'b0, raw, 2'b00} + {3'b000, raw};
    return {1'b0, p[13:3]} + CHAN_OFFSET;
  endfunction

endpackage

// ===== rtl/core/crsf_frame_receiver.sv =====
// Top level of the CRSF frame receiver: configuration register, parser and result stage.
// Depends on crsf_pkg, crsf_parser and crsf_emitter.
//
// Usage: the input channel (in_valid, in_ready, rx_byte) carries one received
// serial byte per transaction. The parser hunts for the configured frame
// address, checks the length and type bytes, stores the payload and runs a
// CRC-8 DVB-S2 over type and payload. The byte that closes a frame produces
// results on the output channel: sixteen channel values for an RC frame, one
// status result for a link statistics frame, or one CRC error result. The
// final one carries last.
// Timing: a byte that does not close a frame is always accepted. The closing
// byte is registered into the result stage, so its first result is valid
// on the next cycle; after that one result leaves per cycle while out_ready
// is high. The result stage holds one frame: a closing byte waits only while
// an earlier frame still has results pending, and it may enter in the cycle
// its predecessor's last result is taken.
// Reset returns the parser to the address hunt, clears the payload store to
// zero and sets the frame address to 0xC8. When out_ready is low the current
// result holds steady and parsing of further bytes goes on.
// The configuration port is APB-style with a single register at address 0.
module crsf_frame_receiver #(
  parameter int MAX_FRAME = crsf_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Byte input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [3:0]        channel_index,
  output logic [11:0]       channel_value,
  output logic signed [8:0] rssi_neg,
  output logic [1:0]        rf_mode,
  output logic [7:0]        uplink_lq,
  output logic              last
);

  logic [7:0]           frame_addr;
  logic                 reg_write;
  logic                 load_ok;
  crsf_pkg::frame_evt_t evt;

  // The register index is the word address; writes to other words are dropped.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready
                     && (paddr[2] == crsf_pkg::REG_FRAME_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_addr <= crsf_pkg::ADDR_RESET;
    end else if (reg_write) begin
      frame_addr <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == crsf_pkg::REG_FRAME_ADDR) ? {24'd0, frame_addr} : 32'd0;

  crsf_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .frame_addr (frame_addr),
    .in_valid   (in_valid),
    .rx_byte    (rx_byte),
    .load_ok    (load_ok),
    .in_ready   (in_ready),
    .evt        (evt)
  );

  crsf_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .load_ok       (load_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .rssi_neg      (rssi_neg),
    .rf_mode       (rf_mode),
    .uplink_lq     (uplink_lq),
    .last          (last)
  );

endmodule

// ===== rtl/core/crsf_parser.sv =====
// Byte-level frame parser: address hunt, length and type checks, CRC and payload store.
// Depends on crsf_pkg; feeds a decoded frame to crsf_emitter.
module crsf_parser #(
  parameter int MAX_FRAME = crsf_pkg::MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            frame_addr,
  input  logic                  in_valid,
  input  logic [7:0]            rx_byte,
  input  logic                  load_ok,
  output logic                  in_ready,
  output crsf_pkg::frame_evt_t  evt
);

  localparam int         LEN_W     = $clog2(MAX_FRAME);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME);

  crsf_pkg::phase_t phase;
  logic [LEN_W-1:0] frame_length;
  logic             is_link;
  logic [LEN_W-1:0] payload_count;
  logic [7:0]       running_crc;
  logic [7:0]       store [crsf_pkg::STORE_BYTES];

  logic [LEN_W-1:0]                     target;
  logic                                 terminal;
  logic                                 accept;
  logic [crsf_pkg::STORE_BYTES*8-1:0]   store_flat;
  logic [7:0]                           rssi_raw;

  assign target   = frame_length - LEN_W'(2);
  // The byte that would close the frame is held off until the result stage can take it.
  assign terminal = (phase == crsf_pkg::PH_BODY) && !(payload_count < target);
  assign in_ready = !terminal || load_ok;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < crsf_pkg::STORE_BYTES; k++) begin
      store_flat[8*k +: 8] = store[k];
    end
  end

  assign rssi_raw = (store[4] == 8'd0) ? store[0] : store[1];

  always_comb begin
    evt       = '0;
    evt.valid = accept && terminal;
    if (rx_byte != running_crc) begin
      evt.kind = crsf_pkg::KIND_CRC_ERR;
    end else if (is_link) begin
      evt.kind      = crsf_pkg::KIND_LINK;
      evt.rssi_neg  = 9'sd0 - $signed({1'b0, rssi_raw});
      evt.rf_mode   = (store[5] > crsf_pkg::RF_MODE_MAX) ? 2'd3 : store[5][1:0];
      evt.uplink_lq = store[2];
    end else begin
      evt.kind = crsf_pkg::KIND_CHAN;
      for (int ch = 0; ch < crsf_pkg::NUM_CHANNELS; ch++) begin
        evt.vals[ch] = crsf_pkg::chan_scale(
            store_flat[ch*crsf_pkg::CH_BITS +: crsf_pkg::CH_BITS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= crsf_pkg::PH_ADDR;
      frame_length  <= '0;
      is_link       <= 1'b0;
      payload_count <= '0;
      running_crc   <= 8'd0;
      for (int k = 0; k < crsf_pkg::STORE_BYTES; k++) begin
        store[k] <= 8'd0;
      end
    end else if (accept) begin
      case (phase)
        crsf_pkg::PH_ADDR: begin
          if (rx_byte == frame_addr) begin
            phase <= crsf_pkg::PH_LEN;
          end
        end
        crsf_pkg::PH_LEN: begin
          if ((rx_byte > crsf_pkg::LEN_MIN_EXCL) && (rx_byte < LEN_LIMIT)) begin
            frame_length <= rx_byte[LEN_W-1:0];
            phase        <= crsf_pkg::PH_TYPE;
          end else begin
            phase <= crsf_pkg::PH_ADDR;
          end
        end
        crsf_pkg::PH_TYPE: begin
          if ((rx_byte == crsf_pkg::TYPE_RC) || (rx_byte == crsf_pkg::TYPE_LINK)) begin
            is_link       <= (rx_byte == crsf_pkg::TYPE_LINK);
            running_crc   <= crsf_pkg::crc8_step(8'd0, rx_byte);
            payload_count <= '0;
            phase         <= crsf_pkg::PH_BODY;
          end else begin
            phase <= crsf_pkg::PH_ADDR;
          end
        end
        crsf_pkg::PH_BODY: begin
          if (!terminal) begin
            // Bytes past the decoded window are never read, so they are not kept.
            for (int k = 0; k < crsf_pkg::STORE_BYTES; k++) begin
              if (payload_count == LEN_W'(k)) begin
                store[k] <= rx_byte;
              end
            end
            running_crc   <= crsf_pkg::crc8_step(running_crc, rx_byte);
            payload_count <= payload_count + LEN_W'(1);
          end else begin
            phase         <= crsf_pkg::PH_ADDR;
            payload_count <= '0;
          end
        end
        default: begin
          phase <= crsf_pkg::PH_ADDR;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_evt_only_in_body: assert property (@(posedge clk) disable iff (rst)
      evt.valid |-> (phase == crsf_pkg::PH_BODY))
    else $error("frame result raised outside the payload phase");
`endif

endmodule

// ===== rtl/core/crsf_emitter.sv =====
// Result stage: holds one decoded frame and hands out its results one per transaction.
// Depends on crsf_pkg; loaded by crsf_parser.
module crsf_emitter (
  input  logic                  clk,
  input  logic                  rst,
  input  crsf_pkg::frame_evt_t  evt,
  output logic                  load_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [3:0]            channel_index,
  output logic [11:0]           channel_value,
  output logic signed [8:0]     rssi_neg,
  output logic [1:0]            rf_mode,
  output logic [7:0]            uplink_lq,
  output logic                  last
);

  crsf_pkg::kind_t                         kind_q;
  logic [3:0]                              idx;
  logic [crsf_pkg::NUM_CHANNELS-1:0][11:0] vals;
  logic signed [8:0]                       rssi_q;
  logic [1:0]                              rf_q;
  logic [7:0]                              lq_q;
  logic                                    last_q;
  logic                                    pop;

  assign pop     = out_valid && out_ready;
  // A new frame may land in the same cycle that the final result leaves.
  assign load_ok = !out_valid || (out_ready && last_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt.valid) begin
      out_valid <= 1'b1;
    end else if (pop && last_q) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) begin
      kind_q <= evt.kind;
      idx    <= 4'd0;
      vals   <= evt.vals;
      rssi_q <= evt.rssi_neg;
      rf_q   <= evt.rf_mode;
      lq_q   <= evt.uplink_lq;
      last_q <= (evt.kind != crsf_pkg::KIND_CHAN);
    end else if (pop && !last_q) begin
      idx    <= idx + 4'd1;
      for (int k = 0; k < crsf_pkg::NUM_CHANNELS - 1; k++) begin
        vals[k] <= vals[k+1];
      end
      vals[crsf_pkg::NUM_CHANNELS-1] <= 12'd0;
      last_q <= (idx == 4'(crsf_pkg::NUM_CHANNELS - 2));
    end
  end

  assign kind          = kind_q;
  assign channel_index = idx;
  assign channel_value = vals[0];
  assign rssi_neg      = rssi_q;
  assign rf_mode       = rf_q;
  assign uplink_lq     = lq_q;
  assign last          = last_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      evt.valid |-> (!out_valid || (out_ready && last_q)))
    else $error("frame loaded over undelivered results");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (kind_q != crsf_pkg::KIND_CHAN)) |-> last_q)
    else $error("status or error result not marked last");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
      (pop && !last_q && !evt.valid) |=> (out_valid && (idx == $past(idx) + 4'd1)))
    else $error("channel index did not advance after a transaction");
`endif

endmodule
